FILE: rtl/led_fade_pattern_player_core_macros.svh
// ----------------------------------------------------------------------------
// LED fade pattern player assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef LED_FADE_PATTERN_PLAYER_CORE_MACROS_SVH
`define LED_FADE_PATTERN_PLAYER_CORE_MACROS_SVH

// Property that must hold in the same cycle.
`define LFPP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define LFPP_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/lfpp_pkg.sv
// ----------------------------------------------------------------------------
// LED fade pattern player package
// Field widths, codes, pattern tables and duty scaling shared by the block.
// ----------------------------------------------------------------------------
package lfpp_pkg;

  localparam int OpcodeW     = 3;
  localparam int HoldFramesW = 5;
  localparam int PctW        = 7;
  localparam int DutyW       = 8;
  localparam int IntervalW   = 16;
  localparam int CfgIndexW   = 2;
  localparam int CfgDataW    = 16;
  localparam int FrameArgW   = 7;

  localparam int MaxFramesDefault = 32;
  localparam int FadeFrames       = 6;
  localparam int FlashFrames      = 10;

  localparam logic [PctW-1:0]      ResetMaxPercent = 7'd100;
  localparam logic [IntervalW-1:0] ResetInterval   = 16'd50;
  localparam logic [PctW-1:0]      PctFull         = 7'd100;

  // floor(p*255/100) equals floor(p*DutyRecip / 2^DutyShift) for p up to 100.
  localparam int                   DutyRecipW = 21;
  localparam logic [DutyRecipW-1:0] DutyRecip = 21'd1336965;
  localparam int                   DutyShift  = 19;
  localparam int                   DutyProdW  = PctW + DutyRecipW;

  // Read-back percent floor(d*100/255) is above 50 exactly when d >= 131,
  // and below 50 exactly when d <= 127.
  localparam logic [DutyW-1:0] OnHighMinDuty = 8'd131;
  localparam logic [DutyW-1:0] OnLowMaxDuty  = 8'd127;

  typedef enum logic [OpcodeW-1:0] {
    OP_TICK     = 3'd0,
    OP_ON       = 3'd1,
    OP_OFF      = 3'd2,
    OP_FLASH    = 3'd3,
    OP_FADE_ON  = 3'd4,
    OP_FADE_OFF = 3'd5
  } opcode_e;

  typedef enum logic [2:0] {
    KIND_ON       = 3'd0,
    KIND_OFF      = 3'd1,
    KIND_FLASH    = 3'd2,
    KIND_FADE_ON  = 3'd3,
    KIND_FADE_OFF = 3'd4
  } kind_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_MAX_PERCENT    = 2'd0,
    CFG_ACTIVE_HIGH    = 2'd1,
    CFG_FRAME_INTERVAL = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [PctW-1:0]      max_percent;
    logic                 active_high;
    logic [IntervalW-1:0] frame_interval;
  } cfg_t;

  typedef struct packed {
    logic [DutyW-1:0] pwm_duty;
    logic             is_on;
    logic             done_res;
  } result_t;

  function automatic logic [PctW-1:0] flash_pct(logic [FrameArgW-1:0] idx);
    logic [PctW-1:0] pct;
    case (idx)
      7'd1, 7'd8: pct = 7'd25;
      7'd2, 7'd7: pct = 7'd50;
      7'd3, 7'd6: pct = 7'd75;
      7'd4, 7'd5: pct = 7'd100;
      default:    pct = 7'd0;
    endcase
    return pct;
  endfunction

  function automatic logic [PctW-1:0] rise_pct(logic [FrameArgW-1:0] idx);
    logic [PctW-1:0] pct;
    case (idx)
      7'd1:       pct = 7'd25;
      7'd2:       pct = 7'd50;
      7'd3:       pct = 7'd75;
      7'd4, 7'd5: pct = 7'd100;
      default:    pct = 7'd0;
    endcase
    return pct;
  endfunction

  function automatic logic [PctW-1:0] fall_pct(logic [FrameArgW-1:0] idx);
    logic [PctW-1:0] pct;
    case (idx)
      7'd0:    pct = 7'd100;
      7'd1:    pct = 7'd75;
      7'd2:    pct = 7'd50;
      7'd3:    pct = 7'd25;
      default: pct = 7'd0;
    endcase
    return pct;
  endfunction

  function automatic logic [PctW-1:0] frame_percent(kind_e kind,
                                                    logic [FrameArgW-1:0] idx,
                                                    logic [FrameArgW-1:0] hold);
    logic [FrameArgW-1:0] rel;
    logic [PctW-1:0]      pct;
    rel = idx - hold;
    case (kind)
      KIND_ON:       pct = PctFull;
      KIND_FLASH:    pct = flash_pct(idx);
      KIND_FADE_ON:  pct = (idx < hold) ? 7'd0 : rise_pct(rel);
      KIND_FADE_OFF: pct = (idx < hold) ? PctFull : fall_pct(rel);
      default:       pct = 7'd0;
    endcase
    return pct;
  endfunction

  function automatic logic [DutyW-1:0] pct_to_duty(logic [PctW-1:0] pct);
    logic [DutyProdW-1:0] prod;
    prod = DutyProdW'(pct) * DutyProdW'(DutyRecip);
    return prod[DutyShift +: DutyW];
  endfunction

endpackage

FILE: rtl/lfpp_cfg_regs.sv
// ----------------------------------------------------------------------------
// LED fade pattern player configuration registers
// Holds clamp, polarity and frame interval, written through a plain port.
// ----------------------------------------------------------------------------
module lfpp_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lfpp_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [lfpp_pkg::CfgDataW-1:0]   cfg_data_i,
  output lfpp_pkg::cfg_t                  cfg_o
);
  import lfpp_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_MAX_PERCENT:    cfg_d.max_percent    = cfg_data_i[PctW-1:0];
        CFG_ACTIVE_HIGH:    cfg_d.active_high    = cfg_data_i[0];
        CFG_FRAME_INTERVAL: cfg_d.frame_interval = cfg_data_i[IntervalW-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_percent    <= ResetMaxPercent;
      cfg_q.active_high    <= 1'b1;
      cfg_q.frame_interval <= ResetInterval;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/lfpp_player.sv
// ----------------------------------------------------------------------------
// LED fade pattern player sequencer
// Pattern state, tick counting and per-request duty and done computation.
// ----------------------------------------------------------------------------
`include "led_fade_pattern_player_core_macros.svh"

module lfpp_player #(
  parameter int MaxFrames = lfpp_pkg::MaxFramesDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic [lfpp_pkg::OpcodeW-1:0]      opcode_i,
  input  logic [lfpp_pkg::HoldFramesW-1:0]  hold_frames_i,
  input  logic                              notify_i,
  input  lfpp_pkg::cfg_t                    cfg_i,
  output lfpp_pkg::result_t                 result_o
);
  import lfpp_pkg::*;

  localparam int FrameW = $clog2(MaxFrames + 1);
  localparam int CmpW   = (FrameW > HoldFramesW) ? FrameW : HoldFramesW;
  localparam logic [CmpW-1:0] HoldLimit = CmpW'(MaxFrames - FadeFrames);

  kind_e                kind_q, kind_d;
  logic [FrameW-1:0]    hold_q, hold_d;
  logic [FrameW-1:0]    index_q, index_d;
  logic [FrameW-1:0]    total_q, total_d;
  logic [IntervalW-1:0] elapsed_q, elapsed_d;
  logic                 notify_q, notify_d;
  logic [DutyW-1:0]     duty_q, duty_d;

  opcode_e              op;
  logic [IntervalW-1:0] elapsed_inc;
  logic                 fire;
  logic [PctW-1:0]      pct_raw, pct_clamp, pct_pol;
  logic [DutyW-1:0]     duty_frame;
  logic [CmpW-1:0]      hold_ext;
  logic [FrameW-1:0]    hold_sat;
  logic                 load, load_fade, done;
  kind_e                load_kind;

  assign op = opcode_e'(opcode_i);

  always_comb begin
    elapsed_inc = (elapsed_q == {IntervalW{1'b1}}) ? elapsed_q : elapsed_q + IntervalW'(1);
    fire        = elapsed_inc > cfg_i.frame_interval;
    pct_raw     = frame_percent(kind_q, FrameArgW'(index_q), FrameArgW'(hold_q));
    pct_clamp   = (pct_raw > cfg_i.max_percent) ? cfg_i.max_percent : pct_raw;
    pct_pol     = cfg_i.active_high ? pct_clamp : PctFull - pct_clamp;
    duty_frame  = pct_to_duty(pct_pol);
    hold_ext    = CmpW'(hold_frames_i);
    hold_sat    = FrameW'((hold_ext > HoldLimit) ? HoldLimit : hold_ext);
  end

  always_comb begin
    kind_d    = kind_q;
    hold_d    = hold_q;
    index_d   = index_q;
    total_d   = total_q;
    elapsed_d = elapsed_q;
    notify_d  = notify_q;
    duty_d    = duty_q;
    done      = 1'b0;
    load      = 1'b0;
    load_fade = 1'b0;
    load_kind = KIND_OFF;

    if (step_i) begin
      case (op)
        OP_TICK: begin
          elapsed_d = elapsed_inc;
          if (fire) begin
            elapsed_d = '0;
            if (index_q < total_q) begin
              duty_d  = duty_frame;
              index_d = index_q + FrameW'(1);
            end else if (notify_q) begin
              notify_d = 1'b0;
              done     = 1'b1;
            end
          end
        end
        OP_ON: begin
          load      = 1'b1;
          load_kind = KIND_ON;
        end
        OP_OFF: begin
          load      = 1'b1;
          load_kind = KIND_OFF;
        end
        OP_FLASH: begin
          load      = 1'b1;
          load_kind = KIND_FLASH;
        end
        OP_FADE_ON: begin
          load      = 1'b1;
          load_fade = 1'b1;
          load_kind = KIND_FADE_ON;
        end
        OP_FADE_OFF: begin
          load      = 1'b1;
          load_fade = 1'b1;
          load_kind = KIND_FADE_OFF;
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end

    // A command restarts its pattern but leaves the tick count running.
    if (load) begin
      kind_d   = load_kind;
      index_d  = '0;
      notify_d = notify_i;
      if (load_fade) begin
        hold_d  = hold_sat;
        total_d = hold_sat + FrameW'(FadeFrames);
      end else begin
        hold_d  = '0;
        total_d = (load_kind == KIND_FLASH) ? FrameW'(FlashFrames) : FrameW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= KIND_OFF;
      hold_q    <= '0;
      index_q   <= '0;
      total_q   <= '0;
      elapsed_q <= '0;
      notify_q  <= 1'b0;
      duty_q    <= '0;
    end else begin
      kind_q    <= kind_d;
      hold_q    <= hold_d;
      index_q   <= index_d;
      total_q   <= total_d;
      elapsed_q <= elapsed_d;
      notify_q  <= notify_d;
      duty_q    <= duty_d;
    end
  end

  always_comb begin
    result_o.pwm_duty = duty_d;
    result_o.is_on    = cfg_i.active_high ? (duty_d >= OnHighMinDuty)
                                          : (duty_d <= OnLowMaxDuty);
    result_o.done_res = done;
  end

  `LFPP_ASSERT(a_index_in_range, index_q <= total_q, "frame index ran past frame total")
  `LFPP_ASSERT(a_done_needs_pending, !done || notify_q, "done pulse without pending notify")
  `LFPP_ASSERT_NEXT(a_load_restarts, step_i && (op != OP_TICK) && (opcode_i <= OP_FADE_OFF), index_q == '0, "command did not restart pattern")

endmodule

FILE: rtl/lfpp_out_buf.sv
// ----------------------------------------------------------------------------
// LED fade pattern player output buffer
// Result register plus skid register so the input side keeps moving.
// ----------------------------------------------------------------------------
`include "led_fade_pattern_player_core_macros.svh"

module lfpp_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lfpp_pkg::result_t  data_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lfpp_pkg::result_t  data_o
);
  import lfpp_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, out_data_d;
  result_t skid_data_q, skid_data_d;
  logic    out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      if (skid_valid_q) begin
        // The skid entry is older, so it goes out first.
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_data_d  = data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign data_o      = out_data_q;

  `LFPP_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q, "skid holds data while output is empty")
  `LFPP_ASSERT(a_no_push_when_full, !(push_i && skid_valid_q), "request pushed into a full buffer")
  `LFPP_ASSERT_NEXT(a_skid_drains, skid_valid_q && !out_stall_i, out_valid_q && !skid_valid_q, "skid entry did not move to output")

endmodule

FILE: rtl/led_fade_pattern_player_core.sv
// ----------------------------------------------------------------------------
// LED fade pattern player core
// Plays brightness patterns on an LED as PWM duty values, one frame per
// interval of millisecond ticks.
// ----------------------------------------------------------------------------
// Usage: each input request carries an opcode (tick or a pattern command),
// a hold count for fades and a notify flag. A request is taken when
// in_valid_i is high and in_stall_o is low; every request gives exactly one
// result (duty, is_on read-back, done pulse) on the output channel.
// A taken request's result is registered in the output buffer. One request
// per cycle is sustained while in_stall_o stays low: the whole step is one
// pass of logic from the pattern state registers into the result register.
// When the receiver stalls, one further result is held in a skid register;
// in_stall_o rises only while that skid register is occupied.
// Reset puts the player in the off pattern with zero duty, an empty output
// side and clamp 100, active-high polarity and a frame interval of 50.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i
// while no request is in flight.
// ----------------------------------------------------------------------------
module led_fade_pattern_player_core #(
  parameter int MaxFrames = lfpp_pkg::MaxFramesDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lfpp_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [lfpp_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lfpp_pkg::OpcodeW-1:0]      opcode_i,
  input  logic [lfpp_pkg::HoldFramesW-1:0]  hold_frames_i,
  input  logic                              notify_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lfpp_pkg::DutyW-1:0]        pwm_duty_o,
  output logic                              is_on_o,
  output logic                              done_res_o
);
  import lfpp_pkg::*;

  cfg_t    cfg;
  result_t step_result;
  result_t out_result;
  logic    buf_full;
  logic    accept;

  assign accept     = in_valid_i && !buf_full;
  assign in_stall_o = buf_full;

  lfpp_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lfpp_player #(
    .MaxFrames (MaxFrames)
  ) u_player (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .opcode_i      (opcode_i),
    .hold_frames_i (hold_frames_i),
    .notify_i      (notify_i),
    .cfg_i         (cfg),
    .result_o      (step_result)
  );

  lfpp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (step_result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (out_result)
  );

  assign pwm_duty_o = out_result.pwm_duty;
  assign is_on_o    = out_result.is_on;
  assign done_res_o = out_result.done_res;

endmodule
